>>> hdl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion shorthands used across the 1-Wire master design.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition b on the same edge
`define OWM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: label");

// condition must never hold
`define OWM_ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
        else $error("assertion failed: label");

`endif

>>> hdl/owm_pkg.sv
// ============================================================================
// owm_pkg
// Shared types and constants of the 1-Wire master slot timer.
// ============================================================================
`timescale 1ns / 1ps

package owm_pkg;

    localparam int DEF_COUNT_BITS = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int OP_W           = 2;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_SLOT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_RESET,
        CMD_SLOT,
        CMD_NONE
    } t_cmd_kind;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_TAIL  = 3'd3,
        PH_SLOT_LOW  = 3'd4,
        PH_SLOT_WAIT = 3'd5,
        PH_SLOT_REST = 3'd6,
        PH_RECOVER   = 3'd7
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_REST     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd6;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [5:0] slot_low_us;
        logic [5:0] sample_wait_us;
        logic [7:0] slot_rest_us;
        logic [5:0] recovery_us;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_us:     10'd492,
        presence_wait_us: 8'd70,
        reset_tail_us:    10'd410,
        slot_low_us:      6'd4,
        sample_wait_us:   6'd1,
        slot_rest_us:     8'd42,
        recovery_us:      6'd2
    };

    typedef struct packed {
        t_cmd_kind kind;
        logic      bit_value;
        logic      bus_level;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hdl/owm_cmd_if.sv
// ============================================================================
// owm_cmd_if
// Request channel: tick or command with the bit to send and the bus level.
// ============================================================================
`timescale 1ns / 1ps

interface owm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       bit_value;
    logic       bus_level;

    modport source (output valid, output op, output bit_value, output bus_level,
                    input ready);
    modport sink   (input valid, input op, input bit_value, input bus_level,
                    output ready);
endinterface

>>> hdl/owm_res_if.sv
// ============================================================================
// owm_res_if
// Result channel: bus drive and status flags for each request.
// ============================================================================
`timescale 1ns / 1ps

interface owm_res_if;
    logic valid;
    logic ready;
    logic drive_low;
    logic busy_res;
    logic done_res;
    logic result_bit;
    logic rejected;

    modport source (output valid, output drive_low, output busy_res,
                    output done_res, output result_bit, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res,
                    input done_res, input result_bit, input rejected,
                    output ready);
endinterface

>>> hdl/onewire_master_slot_timer.sv
// ============================================================================
// onewire_master_slot_timer
// 1-Wire standard-speed bus master timing engine on microsecond ticks.
// ============================================================================
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        op, bit_value, bus_level
//  o_res     out  valid/ready        drive_low, busy_res, done_res,
//                                    result_bit, rejected
//  i_cfg_*   in   write enable only  register index, data
//
//  One request per clock while the result is taken; each request gives one result
//  (decode into a two-entry queue, then sequencer step into the output register).
//  Sequencer steps one request per cycle unless stalled; countdown and phase loop.
//  Reset: synchronous, active low; timing registers return to their defaults.
//  Output stall: the queue fills and ready drops after two held requests.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module onewire_master_slot_timer #(
    parameter int COUNT_BITS = owm_pkg::DEF_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owm_cmd_if.sink                        i_cmd,
    owm_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owm_pkg::CFG_W-1:0]      i_cfg_data
);

    owm_pkg::t_cfg      r_cfg;
    owm_pkg::t_item     w_push_item;
    owm_pkg::t_item     w_pop_item;
    owm_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owm_pkg::REG_RESET_LOW:     r_cfg.reset_low_us     <= i_cfg_data;
                owm_pkg::REG_PRESENCE_WAIT: r_cfg.presence_wait_us <= i_cfg_data[7:0];
                owm_pkg::REG_RESET_TAIL:    r_cfg.reset_tail_us    <= i_cfg_data;
                owm_pkg::REG_SLOT_LOW:      r_cfg.slot_low_us      <= i_cfg_data[5:0];
                owm_pkg::REG_SAMPLE_WAIT:   r_cfg.sample_wait_us   <= i_cfg_data[5:0];
                owm_pkg::REG_SLOT_REST:     r_cfg.slot_rest_us     <= i_cfg_data[7:0];
                owm_pkg::REG_RECOVERY:      r_cfg.recovery_us      <= i_cfg_data[5:0];
                default:                    r_cfg                  <= r_cfg;
            endcase
        end
    end

    owm_front u_front (
        .i_cmd      (i_cmd),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    owm_queue #(
        .DEPTH (owm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_q_status)
    );

    owm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (w_pop_item),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

    `OWM_ASSERT_NEVER(a_done_not_busy, i_clk, i_rst_n, o_res.valid && o_res.done_res && o_res.busy_res)
    `OWM_ASSERT_IMPLY(a_reject_busy, i_clk, i_rst_n, o_res.valid && o_res.rejected, o_res.busy_res)
    `OWM_ASSERT_IMPLY(a_result_done, i_clk, i_rst_n, o_res.valid && o_res.result_bit, o_res.done_res)
    `OWM_ASSERT_NEVER(a_queue_state, i_clk, i_rst_n, w_q_status.full && w_q_status.empty)
    `OWM_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_q_status.empty)

endmodule

>>> hdl/owm_front.sv
// ============================================================================
// owm_front
// Accept requests and classify the opcode for the queue.
// ============================================================================
`timescale 1ns / 1ps

module owm_front (
    owm_cmd_if.sink          i_cmd,
    input  owm_pkg::t_q_status i_q_status,
    output logic             o_push,
    output owm_pkg::t_item   o_item
);

    assign i_cmd.ready = !i_q_status.full;
    assign o_push      = i_cmd.valid && !i_q_status.full;

    always_comb begin
        o_item.bit_value = i_cmd.bit_value;
        o_item.bus_level = i_cmd.bus_level;
        case (owm_pkg::t_op'(i_cmd.op))
            owm_pkg::OP_TICK:  o_item.kind = owm_pkg::CMD_TICK;
            owm_pkg::OP_RESET: o_item.kind = owm_pkg::CMD_RESET;
            owm_pkg::OP_SLOT:  o_item.kind = owm_pkg::CMD_SLOT;
            default:           o_item.kind = owm_pkg::CMD_NONE;
        endcase
    end

endmodule

>>> hdl/owm_queue.sv
// ============================================================================
// owm_queue
// Short FIFO between the classifying front and the timing back end.
// ============================================================================
`timescale 1ns / 1ps

module owm_queue #(
    parameter int DEPTH = owm_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  owm_pkg::t_item     i_item,
    input  logic               i_pop,
    output owm_pkg::t_item     o_item,
    output owm_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    owm_pkg::t_item   r_data [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_item         = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/owm_back.sv
// ============================================================================
// owm_back
// Phase sequencer and countdown; registers one result per request.
// ============================================================================
`timescale 1ns / 1ps

module owm_back #(
    parameter int COUNT_BITS = owm_pkg::DEF_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  owm_pkg::t_cfg      i_cfg,
    input  owm_pkg::t_item     i_item,
    input  owm_pkg::t_q_status i_q_status,
    output logic               o_pop,
    owm_res_if.source          o_res
);

    localparam int EXT_W = (COUNT_BITS > owm_pkg::CFG_W) ? COUNT_BITS : owm_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    owm_pkg::t_phase        r_phase, n_phase;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic                   r_wbit, n_wbit;
    logic                   r_sbit, n_sbit;
    logic                   r_isrst, n_isrst;
    logic                   r_out_valid;
    logic                   r_drive, r_busy, r_done, r_result, r_rej;
    logic                   w_done, w_result, w_rej, w_drive;
    logic                   w_busy;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [owm_pkg::CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(CNT_MAX)) begin
            sat_count = CNT_MAX;
        end else begin
            sat_count = COUNT_BITS'(ext);
        end
    endfunction

    assign o_pop  = !i_q_status.empty && (!r_out_valid || o_res.ready);
    assign w_busy = (r_phase != owm_pkg::PH_IDLE);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_wbit   = r_wbit;
        n_sbit   = r_sbit;
        n_isrst  = r_isrst;
        w_done   = 1'b0;
        w_result = 1'b0;
        w_rej    = 1'b0;
        case (i_item.kind)
            owm_pkg::CMD_RESET: begin
                if (w_busy) begin
                    w_rej = 1'b1;
                end else begin
                    n_isrst = 1'b1;
                    n_wbit  = 1'b0;
                    n_phase = owm_pkg::PH_RST_LOW;
                    n_count = sat_count(i_cfg.reset_low_us);
                end
            end
            owm_pkg::CMD_SLOT: begin
                if (w_busy) begin
                    w_rej = 1'b1;
                end else begin
                    n_isrst = 1'b0;
                    n_wbit  = i_item.bit_value;
                    n_phase = owm_pkg::PH_SLOT_LOW;
                    n_count = sat_count(owm_pkg::CFG_W'(i_cfg.slot_low_us));
                end
            end
            owm_pkg::CMD_TICK: begin
                if (w_busy) begin
                    if (r_count > CNT_ONE) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        case (r_phase)
                            owm_pkg::PH_RST_LOW: begin
                                n_phase = owm_pkg::PH_RST_WAIT;
                                n_count = sat_count(owm_pkg::CFG_W'(i_cfg.presence_wait_us));
                            end
                            owm_pkg::PH_RST_WAIT: begin
                                n_sbit  = !i_item.bus_level;
                                n_phase = owm_pkg::PH_RST_TAIL;
                                n_count = sat_count(i_cfg.reset_tail_us);
                            end
                            owm_pkg::PH_SLOT_LOW: begin
                                n_phase = owm_pkg::PH_SLOT_WAIT;
                                n_count = sat_count(owm_pkg::CFG_W'(i_cfg.sample_wait_us));
                            end
                            owm_pkg::PH_SLOT_WAIT: begin
                                n_sbit  = i_item.bus_level;
                                n_phase = owm_pkg::PH_SLOT_REST;
                                n_count = sat_count(owm_pkg::CFG_W'(i_cfg.slot_rest_us));
                            end
                            owm_pkg::PH_SLOT_REST: begin
                                n_phase = owm_pkg::PH_RECOVER;
                                n_count = sat_count(owm_pkg::CFG_W'(i_cfg.recovery_us));
                            end
                            owm_pkg::PH_RST_TAIL, owm_pkg::PH_RECOVER: begin
                                w_done   = 1'b1;
                                w_result = r_isrst ? (r_sbit & i_item.bus_level) : r_sbit;
                                n_phase  = owm_pkg::PH_IDLE;
                                n_count  = '0;
                            end
                            default: begin
                                n_count = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        case (n_phase)
            owm_pkg::PH_RST_LOW, owm_pkg::PH_SLOT_LOW:    w_drive = 1'b1;
            owm_pkg::PH_SLOT_WAIT, owm_pkg::PH_SLOT_REST: w_drive = !n_wbit;
            default:                                      w_drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owm_pkg::PH_IDLE;
            r_count <= '0;
            r_wbit  <= 1'b0;
            r_sbit  <= 1'b0;
            r_isrst <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_wbit  <= n_wbit;
            r_sbit  <= n_sbit;
            r_isrst <= n_isrst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_drive  <= w_drive;
            r_busy   <= (n_phase != owm_pkg::PH_IDLE);
            r_done   <= w_done;
            r_result <= w_result;
            r_rej    <= w_rej;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.drive_low  = r_drive;
    assign o_res.busy_res   = r_busy;
    assign o_res.done_res   = r_done;
    assign o_res.result_bit = r_result;
    assign o_res.rejected   = r_rej;

endmodule

>>> sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the 1-Wire master slot timer. A short script walks
// idle ticks, dropped commands, presence and no presence, written and read
// slots, and a zero timing register. Random bursts under several timing sets
// follow, from minimum to maximum. A bit-true timer model predicts each status
// word the script does not type, and the bench compares each returned word
// with the oldest prediction. Both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int CNT_TOP      = (1 << owm_pkg::DEF_COUNT_BITS) - 1;
    localparam int SETTLE_TICKS = 6;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [owm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic drive_low;
        logic busy_res;
        logic done_res;
        logic result_bit;
        logic rejected;
    } t_line_status;

    typedef struct packed {
        logic [1:0]   op;
        logic         bit_value;
        logic         bus_level;
        logic         typed;
        t_line_status want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [owm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [owm_pkg::CFG_W-1:0] i_cfg_data;

    owm_cmd_if cmd_ch ();
    owm_res_if res_ch ();

    onewire_master_slot_timer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // timer model state
    owm_pkg::t_phase tm_phase;
    logic [9:0]      tm_count;
    logic            tm_wbit;
    logic            tm_sbit;
    owm_pkg::t_cfg   tm_cfg;

    t_line_status pending_status [$];
    t_line_status oldest_status;
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           hold_kicks  = 0;
    int           hold_seen   = 0;
    int           stall_left  = 0;
    int           sink_roll;
    bit           steady_sink = 1'b0;
    logic [9:0]   timing_vals [7];

    // zero timing: 1; short script: presence, no presence, zero slot_low
    t_script_row bench_script [25] = '{
        '{owm_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 5'b00000},
        '{owm_pkg::OP_NONE,  1'b1, 1'b1, 1'b1, 5'b00000},
        '{owm_pkg::OP_RESET, 1'b1, 1'b1, 1'b1, 5'b11000},
        '{owm_pkg::OP_SLOT,  1'b0, 1'b0, 1'b1, 5'b11001},
        '{owm_pkg::OP_RESET, 1'b0, 1'b0, 1'b1, 5'b11001},
        '{owm_pkg::OP_NONE,  1'b0, 1'b0, 1'b1, 5'b11000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b1, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_RESET, 1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_SLOT,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 5'b00000},
        '{owm_pkg::OP_SLOT,  1'b1, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b1, 1'b0, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000},
        '{owm_pkg::OP_TICK,  1'b0, 1'b1, 1'b0, 5'b00000}
    };

    function automatic void load_phase(input owm_pkg::t_phase ph, input int unsigned ticks);
        tm_phase = ph;
        tm_count = (ticks > CNT_TOP) ? CNT_TOP[9:0] : ticks[9:0];
    endfunction

    function automatic t_line_status step_timer(input logic [1:0] op, input logic bitv,
                                                input logic bus);
        t_line_status s;
        logic         busy_now;
        s        = '0;
        busy_now = (tm_phase != owm_pkg::PH_IDLE);
        if (op == owm_pkg::OP_RESET || op == owm_pkg::OP_SLOT) begin
            if (busy_now) begin
                s.rejected = 1'b1;
            end else if (op == owm_pkg::OP_RESET) begin
                tm_wbit = 1'b0;
                load_phase(owm_pkg::PH_RST_LOW, tm_cfg.reset_low_us);
            end else begin
                tm_wbit = bitv;
                load_phase(owm_pkg::PH_SLOT_LOW, tm_cfg.slot_low_us);
            end
        end else if (op == owm_pkg::OP_TICK && busy_now) begin
            if (tm_count > 1) begin
                tm_count = tm_count - 1'b1;
            end else begin
                tm_count = '0;
                case (tm_phase)
                    owm_pkg::PH_RST_LOW: begin
                        load_phase(owm_pkg::PH_RST_WAIT, tm_cfg.presence_wait_us);
                    end
                    owm_pkg::PH_RST_WAIT: begin
                        tm_sbit = ~bus;
                        load_phase(owm_pkg::PH_RST_TAIL, tm_cfg.reset_tail_us);
                    end
                    owm_pkg::PH_RST_TAIL: begin
                        s.result_bit = tm_sbit & bus;
                        s.done_res   = 1'b1;
                        load_phase(owm_pkg::PH_IDLE, 0);
                    end
                    owm_pkg::PH_SLOT_LOW: begin
                        load_phase(owm_pkg::PH_SLOT_WAIT, tm_cfg.sample_wait_us);
                    end
                    owm_pkg::PH_SLOT_WAIT: begin
                        tm_sbit = bus;
                        load_phase(owm_pkg::PH_SLOT_REST, tm_cfg.slot_rest_us);
                    end
                    owm_pkg::PH_SLOT_REST: begin
                        load_phase(owm_pkg::PH_RECOVER, tm_cfg.recovery_us);
                    end
                    default: begin
                        s.result_bit = tm_sbit;
                        s.done_res   = 1'b1;
                        load_phase(owm_pkg::PH_IDLE, 0);
                    end
                endcase
            end
        end
        s.drive_low = (tm_phase == owm_pkg::PH_RST_LOW || tm_phase == owm_pkg::PH_SLOT_LOW) ||
                      ((tm_phase == owm_pkg::PH_SLOT_WAIT ||
                        tm_phase == owm_pkg::PH_SLOT_REST) && !tm_wbit);
        s.busy_res  = (tm_phase != owm_pkg::PH_IDLE);
        return s;
    endfunction

    task automatic offer_request(input logic [1:0] op, input logic bitv, input logic bus,
                                 input logic typed, input t_line_status want);
        t_line_status predicted;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= op;
        cmd_ch.bit_value <= bitv;
        cmd_ch.bus_level <= bus;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predicted = step_timer(op, bitv, bus);
        pending_status.push_back(typed ? want : predicted);
    endtask

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic pause_sender(input int n);
        if (n > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold the sender until every status word is back, then let the pipe empty
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_timing(input logic [owm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [9:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            owm_pkg::REG_RESET_LOW:     tm_cfg.reset_low_us     = data;
            owm_pkg::REG_PRESENCE_WAIT: tm_cfg.presence_wait_us = data[7:0];
            owm_pkg::REG_RESET_TAIL:    tm_cfg.reset_tail_us    = data;
            owm_pkg::REG_SLOT_LOW:      tm_cfg.slot_low_us      = data[5:0];
            owm_pkg::REG_SAMPLE_WAIT:   tm_cfg.sample_wait_us   = data[5:0];
            owm_pkg::REG_SLOT_REST:     tm_cfg.slot_rest_us     = data[7:0];
            owm_pkg::REG_RECOVERY:      tm_cfg.recovery_us      = data[5:0];
            default: ;
        endcase
    endtask

    task automatic load_timing();
        settle();
        write_timing(owm_pkg::REG_RESET_LOW,     timing_vals[0]);
        write_timing(owm_pkg::REG_PRESENCE_WAIT, timing_vals[1]);
        write_timing(owm_pkg::REG_RESET_TAIL,    timing_vals[2]);
        write_timing(owm_pkg::REG_SLOT_LOW,      timing_vals[3]);
        write_timing(owm_pkg::REG_SAMPLE_WAIT,   timing_vals[4]);
        write_timing(owm_pkg::REG_SLOT_REST,     timing_vals[5]);
        write_timing(owm_pkg::REG_RECOVERY,      timing_vals[6]);
        write_timing(REG_SPARE,                  10'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_small_timing(input int hi);
        foreach (timing_vals[k])
            timing_vals[k] = ($urandom_range(0, 19) == 0) ? 10'd0 : 10'($urandom_range(1, hi));
    endtask

    task automatic random_burst(input int n, input int burst_free);
        int         roll;
        logic [1:0] op;
        for (int k = 0; k < n; k++) begin
            if (k >= burst_free) pause_sender(sender_gap());
            roll = $urandom_range(0, 99);
            if (roll < 70) op = owm_pkg::OP_TICK;
            else if (roll < 82) op = owm_pkg::OP_RESET;
            else if (roll < 94) op = owm_pkg::OP_SLOT;
            else op = owm_pkg::OP_NONE;
            offer_request(op, 1'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    // run one command through to idle, with a stray command now and then
    task automatic finish_sequence(input logic [1:0] op, input logic bitv);
        offer_request(op, bitv, 1'($urandom), 1'b0, '0);
        while (tm_phase != owm_pkg::PH_IDLE) begin
            if ($urandom_range(0, 99) < 3)
                offer_request(owm_pkg::OP_SLOT, 1'($urandom), 1'($urandom), 1'b0, '0);
            else
                offer_request(owm_pkg::OP_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_status.size() == 0) begin
                    $error("status word with nothing pending");
                    mismatches++;
                end else begin
                    oldest_status = pending_status.pop_front();
                    if (res_ch.drive_low !== oldest_status.drive_low) begin
                        $error("drive_low: expected %0b, got %0b",
                               oldest_status.drive_low, res_ch.drive_low);
                        mismatches++;
                    end
                    if (res_ch.busy_res !== oldest_status.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               oldest_status.busy_res, res_ch.busy_res);
                        mismatches++;
                    end
                    if (res_ch.done_res !== oldest_status.done_res) begin
                        $error("done_res: expected %0b, got %0b",
                               oldest_status.done_res, res_ch.done_res);
                        mismatches++;
                    end
                    if (res_ch.result_bit !== oldest_status.result_bit) begin
                        $error("result_bit: expected %0b, got %0b",
                               oldest_status.result_bit, res_ch.result_bit);
                        mismatches++;
                    end
                    if (res_ch.rejected !== oldest_status.rejected) begin
                        $error("rejected: expected %0b, got %0b",
                               oldest_status.rejected, res_ch.rejected);
                        mismatches++;
                    end
                end
            end
            if (hold_seen != hold_kicks) begin
                hold_seen  = hold_kicks;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !steady_sink) begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll >= 95) stall_left = $urandom_range(8, 25);
                else if (sink_roll >= 75) stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.op        <= owm_pkg::OP_TICK;
        cmd_ch.bit_value <= 1'b0;
        cmd_ch.bus_level <= 1'b0;
        tm_cfg   = owm_pkg::CFG_RESET;
        tm_phase = owm_pkg::PH_IDLE;
        tm_count = '0;
        tm_wbit  = 1'b0;
        tm_sbit  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short script on tight timing, slot_low at zero
        timing_vals = '{10'd2, 10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd1};
        load_timing();
        foreach (bench_script[k]) begin
            pause_sender(sender_gap());
            offer_request(bench_script[k].op, bench_script[k].bit_value,
                          bench_script[k].bus_level, bench_script[k].typed,
                          bench_script[k].want);
        end

        // back to back, sink always ready
        steady_sink = 1'b1;
        pick_small_timing(3);
        load_timing();
        random_burst(40, 40);
        steady_sink = 1'b0;

        // long sink hold while requests keep coming
        pick_small_timing(8);
        load_timing();
        hold_kicks++;
        random_burst(60, 20);

        timing_vals = '{default: 10'd1};
        load_timing();
        random_burst(40, 0);
        finish_sequence(owm_pkg::OP_TICK, 1'b0);

        // every register at its top value
        timing_vals = '{default: 10'h3FF};
        load_timing();
        finish_sequence(owm_pkg::OP_SLOT, 1'b0);

        timing_vals = '{default: 10'd0};
        load_timing();
        random_burst(30, 0);

        pick_small_timing(16);
        load_timing();
        random_burst(50, 0);

        timing_vals = '{10'(owm_pkg::CFG_RESET.reset_low_us),
                        10'(owm_pkg::CFG_RESET.presence_wait_us),
                        10'(owm_pkg::CFG_RESET.reset_tail_us),
                        10'(owm_pkg::CFG_RESET.slot_low_us),
                        10'(owm_pkg::CFG_RESET.sample_wait_us),
                        10'(owm_pkg::CFG_RESET.slot_rest_us),
                        10'(owm_pkg::CFG_RESET.recovery_us)};
        load_timing();
        random_burst(45, 0);

        settle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
